// ===== rtl/iocwc_pkg.sv =====
// Package: payload types, register indexes, status codes and sizing constants.
`default_nettype none
package iocwc_pkg;

  localparam int MAX_INFLIGHT_PROBES = 64;
  localparam int WINDOW_BITS         = 20;

  // failed_probes * 100 fits in 13 bits (63 * 100 = 6300)
  localparam int PCT_SCALE = 100;
  localparam int PCT_W     = 13;
  localparam int DIVR_W    = 6;
  localparam int DIV_STEPS = PCT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int PADDR_W = 5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_HEAVY = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SEGMENT_SIZE   = 3'd0;
  localparam logic [2:0] REG_MAX_WINDOW     = 3'd1;
  localparam logic [2:0] REG_LAT_OVERLOAD   = 3'd2;
  localparam logic [2:0] REG_LAT_HEAVY      = 3'd3;
  localparam logic [2:0] REG_FAIL_EPOCH_THR = 3'd4;
  localparam logic [2:0] REG_PROBES_PER_RND = 3'd5;
  localparam logic [2:0] REG_PROBE_OVER_PCT = 3'd6;
  localparam logic [2:0] REG_PROBE_HEAVY_PCT = 3'd7;

  typedef struct packed {
    logic        latency_valid;
    logic [15:0] p99_latency_ms;
    logic [6:0]  probes_outstanding;
    logic [5:0]  failed_probes;
  } epoch_t;

  typedef struct packed {
    logic [1:0]             congestion_status;
    logic [WINDOW_BITS-1:0] window;
    logic [WINDOW_BITS-1:0] slow_start_threshold;
    logic [WINDOW_BITS-1:0] previous_window;
    logic                   congested;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [PCT_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/iocwc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the probe failure percentage.
`default_nettype none
module iocwc_div (
  input  wire                      clk,
  input  wire                      rst,
  input  wire iocwc_pkg::div_req_t req,
  output iocwc_pkg::div_rsp_t      rsp
);
  import iocwc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PCT_W-1:0]     quo;
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    dvs;

  logic [DIVR_W:0] rem_sh;
  logic [DIVR_W:0] diff;
  logic            fits;

  assign rem_sh = {rem, quo[PCT_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
      cnt <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      rem <= fits ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      quo <= {quo[PCT_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ===== rtl/io_congestion_window_controller_unit.sv =====
// Top level: I/O congestion window controller with APB registers and epoch sequencer.
`default_nettype none
// Channel | Dir | Handshake           | Beat
// epoch   | in  | epoch_valid / stall | epoch_t: latency, probe counts of one epoch
// result  | out | result_valid / stall| result_t: status, window, threshold
// apb     | in  | psel/penable/pready | 32-bit register write or read
//
// Steps: an epoch goes from accept to result beat through a load, the bit-serial
//   percentage divider, a step to combine the verdicts and the window update.
// Reset: rst is synchronous; registers return to their defaults, window = 1,
//   threshold = 1024, latency run counter cleared.
// Stalls: epoch_stall is high while an epoch is in work. A finished result waits in
//   the update step while result_stall holds the previous beat in the output register.
module io_congestion_window_controller_unit (
  input  wire                      clk,
  input  wire                      rst,
  // epoch channel
  input  wire                      epoch_valid,
  output logic                     epoch_stall,
  input  wire iocwc_pkg::epoch_t   epoch_data,
  // result channel
  output logic                     result_valid,
  input  wire                      result_stall,
  output iocwc_pkg::result_t       result_data,
  // configuration
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire [iocwc_pkg::PADDR_W-1:0] paddr,
  input  wire [31:0]               pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import iocwc_pkg::*;

  localparam int W = WINDOW_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  // ---------------------------------------------------------------- registers
  logic [19:0] segment_size;
  logic [19:0] max_window;
  logic [15:0] latency_overload_ms;
  logic [15:0] latency_heavy_ms;
  logic [15:0] failed_epoch_threshold;
  logic [5:0]  probes_per_round;
  logic [6:0]  probe_overload_pct;
  logic [6:0]  probe_heavy_pct;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size           <= 20'd1;
      max_window             <= 20'd1024;
      latency_overload_ms    <= 16'd100;
      latency_heavy_ms       <= 16'd500;
      failed_epoch_threshold <= 16'd3;
      probes_per_round       <= 6'd5;
      probe_overload_pct     <= 7'd50;
      probe_heavy_pct        <= 7'd90;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SEGMENT_SIZE:    segment_size           <= pwdata[19:0];
        REG_MAX_WINDOW:      max_window             <= pwdata[19:0];
        REG_LAT_OVERLOAD:    latency_overload_ms    <= pwdata[15:0];
        REG_LAT_HEAVY:       latency_heavy_ms       <= pwdata[15:0];
        REG_FAIL_EPOCH_THR:  failed_epoch_threshold <= pwdata[15:0];
        REG_PROBES_PER_RND:  probes_per_round       <= pwdata[5:0];
        REG_PROBE_OVER_PCT:  probe_overload_pct     <= pwdata[6:0];
        REG_PROBE_HEAVY_PCT: probe_heavy_pct        <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEGMENT_SIZE:    prdata = {12'd0, segment_size};
      REG_MAX_WINDOW:      prdata = {12'd0, max_window};
      REG_LAT_OVERLOAD:    prdata = {16'd0, latency_overload_ms};
      REG_LAT_HEAVY:       prdata = {16'd0, latency_heavy_ms};
      REG_FAIL_EPOCH_THR:  prdata = {16'd0, failed_epoch_threshold};
      REG_PROBES_PER_RND:  prdata = {26'd0, probes_per_round};
      REG_PROBE_OVER_PCT:  prdata = {25'd0, probe_overload_pct};
      REG_PROBE_HEAVY_PCT: prdata = {25'd0, probe_heavy_pct};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  logic [1:0]  state;
  logic        accept;
  epoch_t      ep;
  logic [1:0]  status;
  logic [W-1:0]  cur_window;
  logic [W-1:0]  ss_threshold;
  logic [15:0] failed_epoch_count;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign epoch_stall = (state != S_IDLE);
  assign accept      = epoch_valid && !epoch_stall;

  // failure percentage: failed * 100 / max(probes_per_round, 1)
  assign div_req.start    = accept;
  assign div_req.dividend = PCT_W'(epoch_data.failed_probes) * PCT_W'(PCT_SCALE);
  assign div_req.divisor  = (probes_per_round == '0) ? DIVR_W'(1) : probes_per_round;

  iocwc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // latency observer
  logic [1:0]  lat_now;
  logic [15:0] fec_next;
  logic [1:0]  lat_st;

  always_comb begin
    lat_now = ST_OK;
    if (ep.latency_valid) begin
      if (ep.p99_latency_ms > latency_heavy_ms)         lat_now = ST_HEAVY;
      else if (ep.p99_latency_ms > latency_overload_ms) lat_now = ST_OVER;
    end
    if (lat_now == ST_OK)                fec_next = '0;
    else if (failed_epoch_count != 16'hFFFF) fec_next = failed_epoch_count + 16'd1;
    else                                 fec_next = failed_epoch_count;
    lat_st = (fec_next >= failed_epoch_threshold) ? lat_now : ST_OK;
  end

  // probe observer
  logic [1:0] prb_st;
  logic [1:0] comb_st;

  always_comb begin
    if (ep.probes_outstanding < {1'b0, probes_per_round})
      prb_st = ST_OK;
    else if (32'(ep.probes_outstanding) > 32'(MAX_INFLIGHT_PROBES / 2))
      prb_st = ST_HEAVY;
    else if (div_rsp.quotient > PCT_W'(probe_heavy_pct))
      prb_st = ST_HEAVY;
    else if (div_rsp.quotient > PCT_W'(probe_overload_pct))
      prb_st = ST_OVER;
    else
      prb_st = ST_OK;
    comb_st = (lat_st > prb_st) ? lat_st : prb_st;
  end

  // window update, Reno style
  logic [W:0]   w_raw;
  logic [W:0]   w_dbl;
  logic [W:0]   w_clamp;
  logic [W-1:0] w_new;
  logic [W-1:0] ss_new;

  always_comb begin
    w_dbl  = {cur_window, 1'b0};
    ss_new = ss_threshold;
    case (status)
      ST_OK: begin
        if (cur_window >= ss_threshold)
          w_raw = {1'b0, cur_window} + {1'b0, segment_size};
        else
          w_raw = (w_dbl > {1'b0, ss_threshold}) ? {1'b0, ss_threshold} : w_dbl;
      end
      ST_OVER: begin
        ss_new = cur_window >> 1;
        w_raw  = {1'b0, ss_new};
      end
      default: begin
        ss_new = cur_window >> 1;
        w_raw  = {1'b0, segment_size};
      end
    endcase
    w_clamp = (w_raw > {1'b0, max_window}) ? {1'b0, max_window} : w_raw;
    w_new   = (w_clamp == '0) ? W'(1) : w_clamp[W-1:0];
  end

  logic out_free;
  assign out_free = !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      result_valid       <= 1'b0;
      cur_window         <= W'(1);
      ss_threshold       <= W'(1024);
      failed_epoch_count <= '0;
    end else begin
      // a new beat replaces the one taken at this edge
      if (state == S_UPD && out_free) result_valid <= 1'b1;
      else if (!result_stall)         result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            failed_epoch_count <= fec_next;
            state              <= S_UPD;
          end
        end
        S_UPD: begin
          // wait here while the previous beat is still held
          if (out_free) begin
            cur_window   <= w_new;
            ss_threshold <= ss_new;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) ep <= epoch_data;
    if (state == S_DIV && div_rsp.done) status <= comb_st;
    if (state == S_UPD && out_free) begin
      result_data.congestion_status    <= status;
      result_data.window               <= w_new;
      result_data.slow_start_threshold <= ss_new;
      result_data.previous_window      <= (status != ST_OK) ? cur_window : '0;
      result_data.congested            <= (status != ST_OK);
    end
  end

  // ---------------------------------------------------------------- checks
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DIV)
    else $error("accepted epoch did not start the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.window != '0)
    else $error("result window is zero");

  a_congested_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.congested == (result_data.congestion_status != ST_OK))
    else $error("congested flag disagrees with status");

endmodule
`default_nettype wire
